@@ sv/y2r_pkg.sv @@
package y2r_pkg;

    // Signed working width of every channel sum: Q.14 luma plus chroma terms
    // stays inside +/- 2^23, with one spare bit of headroom.
    localparam int unsigned SUM_W     = 25;
    localparam int unsigned FRAC_BITS = 14;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [8:0]       t_chroma_diff;

    // Q2.14 coefficients (coefficient * 16384, rounded to nearest)
    localparam t_sum C_COEF_RV    = 25'sd22458;
    localparam t_sum C_COEF_GV    = 25'sd11436;
    localparam t_sum C_COEF_GU    = 25'sd5532;
    localparam t_sum C_COEF_BU    = 25'sd28384;
    localparam t_sum C_ROUND_HALF = 25'sd8192;
    localparam t_sum C_CHAN_MAX   = 25'sd255;

    localparam logic [7:0] C_CHROMA_OFFSET = 8'd128;

    // Chroma contributions shared by both pixels of a macropixel
    typedef struct packed {
        t_sum r_term;
        t_sum g_term;
        t_sum b_term;
    } t_chroma_terms;

    // Remove the 128 offset from a chroma byte: flip the top bit, sign-extend.
    function automatic t_chroma_diff chroma_diff(input logic [7:0] c);
        logic [7:0] flipped;
        flipped = c ^ C_CHROMA_OFFSET;
        return t_chroma_diff'(signed'(flipped));
    endfunction

    // Round a Q.14 sum to nearest (ties up), then clamp to 0..255.
    function automatic logic [7:0] round_clamp(input t_sum s);
        t_sum biased;
        t_sum whole;
        logic [7:0] res;
        biased = s + C_ROUND_HALF;
        whole  = biased >>> FRAC_BITS;
        if (whole < 0) begin
            res = 8'd0;
        end else if (whole > C_CHAN_MAX) begin
            res = 8'd255;
        end else begin
            res = whole[7:0];
        end
        return res;
    endfunction

endpackage

@@ sv/y2r_if.sv @@
interface y2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
    modport monitor (input valid, ready, luma_first, chroma_blue, luma_second,
                     chroma_red);
endinterface

interface y2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;

    modport source (output valid, red_first, green_first, blue_first,
                    red_second, green_second, blue_second,
                    input ready);
    modport sink (input valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second,
                  output ready);
    modport monitor (input valid, ready, red_first, green_first, blue_first,
                     red_second, green_second, blue_second);
endinterface

@@ sv/yuyv_to_rgb_converter.sv @@
// YUYV 4:2:2 to RGB888 converter. Each input transaction carries one packed
// macropixel (Y0, U, Y1, V); each output transaction carries the two RGB888
// pixels it encodes, both using the shared U and V. Channels follow
// R = Y + 1.370705(V-128), G = Y - 0.698001(V-128) - 0.337633(U-128) and
// B = Y + 1.732446(U-128) with Q2.14 coefficients, rounded to nearest (ties
// up) and clamped to 0..255. The block is a two-register pipeline: an input
// register captures the macropixel, the conversion runs as combinational
// constant multiplies and adds, and an output register holds the result.
// Throughput is one transaction per clock unless the output stalls; each
// transaction moves from the input register to the output register.
// Back-pressure from the output propagates to i_yuyv.ready only once both
// registers are full; there are no configuration registers or other state.
module yuyv_to_rgb_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    y2r_in_if.sink       i_yuyv,
    y2r_out_if.source    o_rgb
);
    import y2r_pkg::*;

    // Input stage
    logic       r_s1_valid;
    logic [7:0] r_y0;
    logic [7:0] r_u;
    logic [7:0] r_y1;
    logic [7:0] r_v;

    // Output stage
    logic       r_out_valid;
    logic [7:0] r_red_first;
    logic [7:0] r_green_first;
    logic [7:0] r_blue_first;
    logic [7:0] r_red_second;
    logic [7:0] r_green_second;
    logic [7:0] r_blue_second;

    logic          out_load;
    logic          s1_load;
    t_chroma_terms terms;
    logic [7:0]    n_red_first;
    logic [7:0]    n_green_first;
    logic [7:0]    n_blue_first;
    logic [7:0]    n_red_second;
    logic [7:0]    n_green_second;
    logic [7:0]    n_blue_second;

    // Advance the output register whenever it is empty or being drained;
    // advance the input register whenever its contents move on.
    assign out_load     = !r_out_valid || o_rgb.ready;
    assign s1_load      = !r_s1_valid || out_load;
    assign i_yuyv.ready = s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_yuyv.valid;
        end
    end

    // Payload needs no reset; capture only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (s1_load && i_yuyv.valid) begin
            r_y0 <= i_yuyv.luma_first;
            r_u  <= i_yuyv.chroma_blue;
            r_y1 <= i_yuyv.luma_second;
            r_v  <= i_yuyv.chroma_red;
        end
    end

    // Chroma terms are computed once and shared by both pixels.
    y2r_chroma u_chroma (
        .i_chroma_blue (r_u),
        .i_chroma_red  (r_v),
        .o_terms       (terms)
    );

    y2r_pixel u_pixel_first (
        .i_luma  (r_y0),
        .i_terms (terms),
        .o_red   (n_red_first),
        .o_green (n_green_first),
        .o_blue  (n_blue_first)
    );

    y2r_pixel u_pixel_second (
        .i_luma  (r_y1),
        .i_terms (terms),
        .o_red   (n_red_second),
        .o_green (n_green_second),
        .o_blue  (n_blue_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Hold the result while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_red_first    <= n_red_first;
            r_green_first  <= n_green_first;
            r_blue_first   <= n_blue_first;
            r_red_second   <= n_red_second;
            r_green_second <= n_green_second;
            r_blue_second  <= n_blue_second;
        end
    end

    assign o_rgb.valid        = r_out_valid;
    assign o_rgb.red_first    = r_red_first;
    assign o_rgb.green_first  = r_green_first;
    assign o_rgb.blue_first   = r_blue_first;
    assign o_rgb.red_second   = r_red_second;
    assign o_rgb.green_second = r_green_second;
    assign o_rgb.blue_second  = r_blue_second;

endmodule

@@ sv/y2r_chroma.sv @@
module y2r_chroma (
    input  logic [7:0]             i_chroma_blue,
    input  logic [7:0]             i_chroma_red,
    output y2r_pkg::t_chroma_terms o_terms
);
    import y2r_pkg::*;

    t_sum du;
    t_sum dv;

    assign du = t_sum'(chroma_diff(i_chroma_blue));
    assign dv = t_sum'(chroma_diff(i_chroma_red));

    assign o_terms.r_term = C_COEF_RV * dv;
    assign o_terms.g_term = -((C_COEF_GV * dv) + (C_COEF_GU * du));
    assign o_terms.b_term = C_COEF_BU * du;

endmodule

@@ sv/y2r_pixel.sv @@
module y2r_pixel (
    input  logic [7:0]             i_luma,
    input  y2r_pkg::t_chroma_terms i_terms,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue
);
    import y2r_pkg::*;

    t_sum base;

    // Luma in Q.14
    assign base = signed'({3'b000, i_luma, 14'd0});

    assign o_red   = round_clamp(base + i_terms.r_term);
    assign o_green = round_clamp(base + i_terms.g_term);
    assign o_blue  = round_clamp(base + i_terms.b_term);

endmodule

@@ sv/y2r_checker.sv @@
module y2r_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    y2r_in_if.sink    i_yuyv,
    y2r_out_if.source o_rgb
);

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rgb.valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb.valid && !o_rgb.ready) |=>
        (o_rgb.valid && $stable(o_rgb.red_first) && $stable(o_rgb.green_first)
         && $stable(o_rgb.blue_first) && $stable(o_rgb.red_second)
         && $stable(o_rgb.green_second) && $stable(o_rgb.blue_second)))
        else $error("stalled output transaction changed");

    // Input back-pressure only when the output side is full and stalled.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_yuyv.ready |-> (o_rgb.valid && !o_rgb.ready))
        else $error("input stalled without output back-pressure");

    // With the sink ready, an accepted transaction passes the input and output registers to the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_yuyv.valid && i_yuyv.ready && o_rgb.ready) ##1 o_rgb.ready
        |=> o_rgb.valid)
        else $error("result missing two cycles after acceptance");

endmodule

bind yuyv_to_rgb_converter y2r_checker u_y2r_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_yuyv  (i_yuyv),
    .o_rgb   (o_rgb)
);
